/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file of the i2c bit engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/i2cmbe_pkg.sv */
// types and constants shared by the i2c master bit engine
`timescale 1ns / 1ps
`default_nettype none
package i2cmbe_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       sda_level;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_done;
    logic       command_dropped;
  } out_item_t;

  // classified tick as it travels from front to back
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data_byte;
    logic       sda_level;
  } work_item_t;

  localparam int unsigned CfgDataWidth = 12;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_LONG_PHASE  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SHORT_PHASE = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_READ_SAMPLE = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ACK_WAIT    = 2'd3;

  typedef struct packed {
    logic [7:0]  long_ticks;
    logic [7:0]  short_ticks;
    logic [7:0]  sample_ticks;
    logic [11:0] ack_ticks;
  } cfg_t;

  localparam logic [7:0]  LongPhaseReset  = 8'd20;
  localparam logic [7:0]  ShortPhaseReset = 8'd6;
  localparam logic [7:0]  ReadSampleReset = 8'd10;
  localparam logic [11:0] AckWaitReset    = 12'd1000;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

endpackage
`default_nettype wire

/* src/i2c_master_bit_engine_unit.sv */
// i2c master bit engine top level: config registers, front, queue and back
// path: a tick beat accepted into the front register passes the queue into the back's result register
// throughput: one tick beat per cycle while the result side does not stall, set by the phase update in the back
// stalls on the result side back up through the two-entry queue to the input ready
// reset: asynchronous, active low; bus released high, sequencer idle, registers at defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module i2c_master_bit_engine_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  i2cmbe_pkg::in_item_t                    in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output i2cmbe_pkg::out_item_t                   out_data_o,
  input  logic                                    cfg_we_i,
  input  logic [i2cmbe_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [i2cmbe_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);
  import i2cmbe_pkg::*;

  // timing registers; the user must write them only while the engine is idle, the block does not enforce it
  cfg_t       cfg_q;

  // front to queue
  logic       f_valid;
  logic       f_ready;
  work_item_t f_item;

  // queue to back
  logic       b_valid;
  logic       b_ready;
  work_item_t b_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks   <= LongPhaseReset;
      cfg_q.short_ticks  <= ShortPhaseReset;
      cfg_q.sample_ticks <= ReadSampleReset;
      cfg_q.ack_ticks    <= AckWaitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LONG_PHASE:  cfg_q.long_ticks   <= cfg_wdata_i[7:0];
        CFG_SHORT_PHASE: cfg_q.short_ticks  <= cfg_wdata_i[7:0];
        CFG_READ_SAMPLE: cfg_q.sample_ticks <= cfg_wdata_i[7:0];
        CFG_ACK_WAIT:    cfg_q.ack_ticks    <= cfg_wdata_i[11:0];
        default:         cfg_q              <= cfg_q;
      endcase
    end
  end

  // front: registers each tick beat and decodes its command
  i2cmbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // queue: lets the front keep taking beats while the result side stalls
  i2cmbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_item)
  );

  // back: phase sequencer, one tick per cycle while the result is taken, result held in an output register
  i2cmbe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (b_valid),
    .item_ready_o (b_ready),
    .item_i       (b_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // a dropped command only happens while a sequence runs
  `ASSERT_IMPLIES(a_drop_busy, out_valid_o && out_data_o.command_dropped, out_data_o.busy_res, "command dropped while idle")
  // the last tick of a read belongs to the read and still has scl high
  `ASSERT_IMPLIES(a_done_busy, out_valid_o && out_data_o.read_done, out_data_o.busy_res && out_data_o.scl_drive, "read done outside a read hold")
  // an accepted beat is always held by the front on the next cycle
  `ASSERT_NEXT(a_front_takes, in_valid_i && in_ready_o, f_valid, "accepted beat lost in front")

endmodule
`default_nettype wire

/* src/i2cmbe_front.sv */
// front stage: takes input beats and classifies the command
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  i2cmbe_pkg::in_item_t    in_data_i,
  output logic                    item_valid_o,
  input  logic                    item_ready_i,
  output i2cmbe_pkg::work_item_t  item_o
);
  import i2cmbe_pkg::*;

  logic       valid_q;
  work_item_t item_q;
  work_item_t item_d;

  // codes above read byte carry no command
  function automatic cmd_e decode_cmd(input logic [2:0] code);
    cmd_e k;
    case (code)
      CMD_START: k = CMD_START;
      CMD_STOP:  k = CMD_STOP;
      CMD_WRITE: k = CMD_WRITE;
      CMD_READ:  k = CMD_READ;
      default:   k = CMD_NONE;
    endcase
    return k;
  endfunction

  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    item_d.kind      = decode_cmd(in_data_i.command);
    item_d.data_byte = in_data_i.data_byte;
    item_d.sda_level = in_data_i.sda_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

/* src/i2cmbe_queue.sv */
// short fifo between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  output logic                    push_ready_o,
  input  i2cmbe_pkg::work_item_t  push_data_i,
  output logic                    pop_valid_o,
  input  logic                    pop_ready_i,
  output i2cmbe_pkg::work_item_t  pop_data_o
);
  import i2cmbe_pkg::*;

  localparam logic [QueuePtrW-1:0] LastPtr = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] FullCnt = QueueCntW'(QueueDepth);
  localparam logic [QueuePtrW-1:0] PtrOne  = QueuePtrW'(1);
  localparam logic [QueueCntW-1:0] CntOne  = QueueCntW'(1);

  work_item_t            mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    end
    if (push && !pop) begin
      count_d = count_q + CntOne;
    end else if (pop && !push) begin
      count_d = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* src/i2cmbe_back.sv */
// back stage: scl/sda phase sequencer with a registered result
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  i2cmbe_pkg::cfg_t        cfg_i,
  input  logic                    item_valid_i,
  output logic                    item_ready_o,
  input  i2cmbe_pkg::work_item_t  item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output i2cmbe_pkg::out_item_t   out_data_o
);
  import i2cmbe_pkg::*;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_C    = 5'd3;
  localparam logic [4:0] PH_SP_A    = 5'd4;
  localparam logic [4:0] PH_SP_B    = 5'd5;
  localparam logic [4:0] PH_WR_LOW  = 5'd6;
  localparam logic [4:0] PH_WR_SET  = 5'd7;
  localparam logic [4:0] PH_WR_HIGH = 5'd8;
  localparam logic [4:0] PH_WR_END  = 5'd9;
  localparam logic [4:0] PH_AK_REL  = 5'd10;
  localparam logic [4:0] PH_AK_HIGH = 5'd11;
  localparam logic [4:0] PH_AK_WAIT = 5'd12;
  localparam logic [4:0] PH_AK_LOW  = 5'd13;
  localparam logic [4:0] PH_RD_LOW  = 5'd14;
  localparam logic [4:0] PH_RD_SAMP = 5'd15;
  localparam logic [4:0] PH_RD_HOLD = 5'd16;

  typedef struct packed {
    logic [4:0]  phase;
    logic        scl;
    logic        sda;
    logic [11:0] cnt;
    logic [7:0]  shf;
  } seq_t;

  localparam seq_t SeqReset = '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, cnt: 12'd0, shf: 8'd0};

  seq_t       seq_q, seq_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] last_q, last_d;
  logic       out_valid_q;
  out_item_t  out_q, res;
  logic       fire;
  logic [4:0] start_ph, next_ph;
  seq_t       s0, s1;

  // a zero length counts as one tick
  function automatic logic [11:0] min_one(input logic [7:0] v);
    return (v == 8'd0) ? 12'd1 : {4'd0, v};
  endfunction

  function automatic seq_t enter_phase(input seq_t s, input logic [4:0] p, input cfg_t c);
    seq_t r;
    r       = s;
    r.phase = p;
    case (p)
      PH_ST_A:    begin r.scl = 1'b1; r.sda = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_ST_B:    begin r.sda = 1'b0; r.cnt = min_one(c.long_ticks); end
      PH_ST_C:    begin r.scl = 1'b0; r.cnt = min_one(c.short_ticks); end
      PH_SP_A:    begin r.sda = 1'b0; r.scl = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_SP_B:    begin r.sda = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_WR_LOW:  begin r.scl = 1'b0; r.cnt = min_one(c.short_ticks); end
      PH_WR_SET:  begin
        r.sda = s.shf[7];
        r.shf = {s.shf[6:0], 1'b0};
        r.cnt = min_one(c.long_ticks);
      end
      PH_WR_HIGH: begin r.scl = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_WR_END:  begin r.scl = 1'b0; r.cnt = min_one(c.short_ticks); end
      PH_AK_REL:  begin r.sda = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_AK_HIGH: begin r.scl = 1'b1; r.cnt = min_one(c.long_ticks); end
      PH_AK_WAIT: begin r.cnt = c.ack_ticks; end
      PH_AK_LOW:  begin r.scl = 1'b0; r.cnt = min_one(c.short_ticks); end
      PH_RD_LOW:  begin r.sda = 1'b1; r.scl = 1'b0; r.cnt = min_one(c.long_ticks); end
      PH_RD_SAMP: begin r.scl = 1'b1; r.cnt = min_one(c.sample_ticks); end
      PH_RD_HOLD: begin r.cnt = min_one(c.long_ticks); end
      default:    begin r.phase = PH_IDLE; r.cnt = 12'd0; end
    endcase
    return r;
  endfunction

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign fire         = item_valid_i && item_ready_o;

  always_comb begin
    s0                  = seq_q;
    bit_d               = bit_q;
    last_d              = last_q;
    start_ph            = PH_IDLE;
    next_ph             = PH_IDLE;
    res                 = '0;
    res.command_dropped = 1'b0;

    // command entry, same tick
    if (seq_q.phase == PH_IDLE) begin
      bit_d = 4'd0;
      case (item_i.kind)
        CMD_START: start_ph = PH_ST_A;
        CMD_STOP:  start_ph = PH_SP_A;
        CMD_WRITE: begin start_ph = PH_WR_LOW; s0.shf = item_i.data_byte; end
        CMD_READ:  begin start_ph = PH_RD_LOW; s0.shf = 8'd0; end
        default:   start_ph = PH_IDLE;
      endcase
      s0 = enter_phase(s0, start_ph, cfg_i);
    end else if (item_i.kind != CMD_NONE) begin
      res.command_dropped = 1'b1;
    end

    res.scl_drive = s0.scl;
    res.sda_drive = s0.sda;
    res.busy_res  = (s0.phase != PH_IDLE);

    // countdown and phase advance
    s1 = s0;
    if (s0.phase != PH_IDLE) begin
      if (s1.cnt != 12'd0) begin
        s1.cnt = s1.cnt - 12'd1;
      end
      if (s1.cnt == 12'd0) begin
        case (s1.phase)
          PH_ST_A:    next_ph = PH_ST_B;
          PH_ST_B:    next_ph = PH_ST_C;
          PH_SP_A:    next_ph = PH_SP_B;
          PH_WR_LOW:  next_ph = PH_WR_SET;
          PH_WR_SET:  next_ph = PH_WR_HIGH;
          PH_WR_HIGH: begin
            bit_d   = bit_d + 4'd1;
            next_ph = bit_d[3] ? PH_WR_END : PH_WR_LOW;
          end
          PH_WR_END:  next_ph = PH_AK_REL;
          PH_AK_REL:  next_ph = PH_AK_HIGH;
          PH_AK_HIGH: next_ph = (cfg_i.ack_ticks != 12'd0) ? PH_AK_WAIT : PH_AK_LOW;
          PH_AK_WAIT: next_ph = PH_AK_LOW;
          PH_RD_LOW:  next_ph = PH_RD_SAMP;
          PH_RD_SAMP: begin
            s1.shf  = {s1.shf[6:0], item_i.sda_level};
            next_ph = PH_RD_HOLD;
          end
          PH_RD_HOLD: begin
            bit_d = bit_d + 4'd1;
            if (bit_d[3]) begin
              s1.scl        = 1'b0;
              last_d        = s1.shf;
              res.read_done = 1'b1;
              next_ph       = PH_IDLE;
            end else begin
              next_ph = PH_RD_LOW;
            end
          end
          default:    next_ph = PH_IDLE;
        endcase
        s1 = enter_phase(s1, next_ph, cfg_i);
      end
    end

    seq_d         = s1;
    res.read_byte = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SeqReset;
      bit_q       <= 4'd0;
      last_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else if (fire) begin
      seq_q       <= seq_d;
      bit_q       <= bit_d;
      last_q      <= last_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* test/i2c_master_bit_engine_checker.sv */
// checker for the i2c master bit engine: bus level predictor and in-order compare
`timescale 1ns / 1ps
module i2c_master_bit_engine_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  i2cmbe_pkg::in_item_t                in_data_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  i2cmbe_pkg::out_item_t               out_data_i,
  input  logic                                cfg_we_i,
  input  logic [i2cmbe_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [i2cmbe_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import i2cmbe_pkg::*;

  typedef enum logic [4:0] {
    SQ_IDLE,
    SQ_START_HI,
    SQ_START_SDA,
    SQ_START_SCL,
    SQ_STOP_SCL,
    SQ_STOP_SDA,
    SQ_WR_LOW,
    SQ_WR_DATA,
    SQ_WR_HIGH,
    SQ_WR_LAST,
    SQ_ACK_REL,
    SQ_ACK_HIGH,
    SQ_ACK_HOLD,
    SQ_ACK_LOW,
    SQ_RD_LOW,
    SQ_RD_SAMPLE,
    SQ_RD_HOLD
  } seq_phase_e;

  // timing registers as the block holds them
  logic [7:0]  long_t;
  logic [7:0]  short_t;
  logic [7:0]  sample_t;
  logic [11:0] ack_t;

  // sequencer state
  seq_phase_e  phase;
  logic [3:0]  bit_idx;
  logic [11:0] countdown;
  logic [7:0]  shreg;
  logic        scl_q;
  logic        sda_q;
  logic [7:0]  last_rd;
  logic        done_q;

  out_item_t   bus_levels_q[$];
  int          mismatches = 0;
  int          waiting_n  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting_n;

  // load the pin levels and the length of a new phase
  task automatic open_phase(input seq_phase_e nxt);
    logic [11:0] len;
    len = '0;
    case (nxt)
      SQ_START_HI: begin
        scl_q = 1'b1;
        sda_q = 1'b1;
        len   = 12'(long_t);
      end
      SQ_START_SDA: begin
        sda_q = 1'b0;
        len   = 12'(long_t);
      end
      SQ_START_SCL: begin
        scl_q = 1'b0;
        len   = 12'(short_t);
      end
      SQ_STOP_SCL: begin
        sda_q = 1'b0;
        scl_q = 1'b1;
        len   = 12'(long_t);
      end
      SQ_STOP_SDA: begin
        sda_q = 1'b1;
        len   = 12'(long_t);
      end
      SQ_WR_LOW, SQ_WR_LAST, SQ_ACK_LOW: begin
        scl_q = 1'b0;
        len   = 12'(short_t);
      end
      SQ_WR_DATA: begin
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        len   = 12'(long_t);
      end
      SQ_WR_HIGH, SQ_ACK_HIGH: begin
        scl_q = 1'b1;
        len   = 12'(long_t);
      end
      SQ_ACK_REL: begin
        sda_q = 1'b1;
        len   = 12'(long_t);
      end
      SQ_ACK_HOLD: len = ack_t;
      SQ_RD_LOW: begin
        sda_q = 1'b1;
        scl_q = 1'b0;
        len   = 12'(long_t);
      end
      SQ_RD_SAMPLE: begin
        scl_q = 1'b1;
        len   = 12'(sample_t);
      end
      SQ_RD_HOLD: len = 12'(long_t);
      default: nxt = SQ_IDLE;
    endcase
    // a zero length counts as one, except for the ack hold
    if (nxt != SQ_IDLE && nxt != SQ_ACK_HOLD && len == '0) len = 12'd1;
    phase     = nxt;
    countdown = len;
  endtask

  // one tick of the sequencer: pin levels, last read byte and flags
  task automatic predict_bus_levels(input in_item_t beat, output out_item_t res);
    logic drop;
    drop   = 1'b0;
    done_q = 1'b0;
    if (phase == SQ_IDLE) begin
      bit_idx = '0;
      case (beat.command)
        CMD_START: open_phase(SQ_START_HI);
        CMD_STOP:  open_phase(SQ_STOP_SCL);
        CMD_WRITE: begin
          shreg = beat.data_byte;
          open_phase(SQ_WR_LOW);
        end
        CMD_READ: begin
          shreg = '0;
          open_phase(SQ_RD_LOW);
        end
        default: ;
      endcase
    end else if (beat.command >= CMD_START && beat.command <= CMD_READ) begin
      drop = 1'b1;
    end

    res.scl_drive = scl_q;
    res.sda_drive = sda_q;
    res.busy_res  = (phase != SQ_IDLE);

    if (phase != SQ_IDLE) begin
      if (countdown != '0) countdown = countdown - 12'd1;
      if (countdown == '0) begin
        case (phase)
          SQ_START_HI:  open_phase(SQ_START_SDA);
          SQ_START_SDA: open_phase(SQ_START_SCL);
          SQ_STOP_SCL:  open_phase(SQ_STOP_SDA);
          SQ_WR_LOW:    open_phase(SQ_WR_DATA);
          SQ_WR_DATA:   open_phase(SQ_WR_HIGH);
          SQ_WR_HIGH: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) open_phase(SQ_WR_LAST);
            else open_phase(SQ_WR_LOW);
          end
          SQ_WR_LAST: open_phase(SQ_ACK_REL);
          SQ_ACK_REL: open_phase(SQ_ACK_HIGH);
          SQ_ACK_HIGH: begin
            if (ack_t != '0) open_phase(SQ_ACK_HOLD);
            else open_phase(SQ_ACK_LOW);
          end
          SQ_ACK_HOLD: open_phase(SQ_ACK_LOW);
          SQ_RD_LOW:   open_phase(SQ_RD_SAMPLE);
          SQ_RD_SAMPLE: begin
            shreg = {shreg[6:0], beat.sda_level};
            open_phase(SQ_RD_HOLD);
          end
          SQ_RD_HOLD: begin
            bit_idx = bit_idx + 4'd1;
            if (bit_idx >= 4'd8) begin
              scl_q   = 1'b0;
              last_rd = shreg;
              done_q  = 1'b1;
              open_phase(SQ_IDLE);
            end else begin
              open_phase(SQ_RD_LOW);
            end
          end
          default: open_phase(SQ_IDLE);
        endcase
      end
    end

    res.read_byte       = last_rd;
    res.read_done       = done_q;
    res.command_dropped = drop;
  endtask

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    $display("%0t ns mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      long_t    = LongPhaseReset;
      short_t   = ShortPhaseReset;
      sample_t  = ReadSampleReset;
      ack_t     = AckWaitReset;
      phase     = SQ_IDLE;
      bit_idx   = '0;
      countdown = '0;
      shreg     = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      last_rd   = '0;
      done_q    = 1'b0;
      bus_levels_q.delete();
      waiting_n = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LONG_PHASE:  long_t   = cfg_wdata_i[7:0];
          CFG_SHORT_PHASE: short_t  = cfg_wdata_i[7:0];
          CFG_READ_SAMPLE: sample_t = cfg_wdata_i[7:0];
          CFG_ACK_WAIT:    ack_t    = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (bus_levels_q.size() == 0) begin
          $display("%0t ns result beat with none expected: expected nothing, actual %h",
                   $time, got);
          mismatches++;
        end else begin
          want = bus_levels_q.pop_front();
          if (got.scl_drive !== want.scl_drive)
            report_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
          if (got.sda_drive !== want.sda_drive)
            report_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
          if (got.busy_res !== want.busy_res)
            report_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          if (got.read_byte !== want.read_byte)
            report_field("read_byte", want.read_byte, got.read_byte);
          if (got.read_done !== want.read_done)
            report_field("read_done", 8'(want.read_done), 8'(got.read_done));
          if (got.command_dropped !== want.command_dropped)
            report_field("command_dropped", 8'(want.command_dropped),
                         8'(got.command_dropped));
        end
      end

      if (in_valid_i && in_ready_i) begin
        predict_bus_levels(in_data_i, want);
        bus_levels_q.push_back(want);
      end

      waiting_n = bus_levels_q.size();
    end
  end

endmodule

/* test/tb_i2c_master_bit_engine_unit.sv */
// top of the i2c master bit engine testbench: clock, reset, tick stimulus and verdict
`timescale 1ns / 1ps
module tb_i2c_master_bit_engine_unit;
  import i2cmbe_pkg::*;

  localparam int          ClkHalfNs    = 6;
  localparam int          HoldCycles   = 48;   // long receiver hold-off, fills the queue
  localparam int          SettleCycles = 8;    // margin after the last result beat, before register writes
  localparam int unsigned LimitNs      = 1_200_000;

  // how the sda input is chosen while the sequencer runs
  localparam int SdaLow  = 0;
  localparam int SdaHigh = 1;
  localparam int SdaRand = 2;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  in_item_t                in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  out_item_t               out_data_o;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  int fail_n;
  int pending_n;

  // beat bookkeeping: output beat n belongs to input beat n
  int beats_in   = 0;
  int beats_out  = 0;
  int cmd_mark   = 0;   // index of the last tick beat that carried a command
  int idle_mark  = 0;   // index of the last result beat that showed the bus idle

  // idling controls, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long hold-off requests, served by the receiver process
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left  = 0;

  i2c_master_bit_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  i2c_master_bit_engine_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_n),
    .pending_o    (pending_n)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalfNs) clk_i = ~clk_i;
  end

  // safety net against a hung block
  initial begin
    #(LimitNs);
    $display("status: fail");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (hold_asked != hold_given) begin
        hold_given  = hold_asked;
        hold_left   = HoldCycles - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // track result beats to know when the sequencer has gone back to idle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (!out_data_o.busy_res) idle_mark = beats_out;
    end
  end

  // offer one tick beat, with random gaps, and wait until it is taken
  // entered and left at a falling edge; valid stays high for a following beat
  task automatic send_tick(input in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_in++;
    if (beat.command != CMD_NONE) cmd_mark = beats_in;
    @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic [2:0] code, input logic [7:0] data);
    in_item_t beat;
    beat.command   = code;
    beat.data_byte = data;
    beat.sda_level = 1'($urandom);
    send_tick(beat);
  endtask

  // plain ticks until a result beat after the last command shows the bus idle
  task automatic run_to_idle(input int sda_pick);
    in_item_t beat;
    while (idle_mark <= cmd_mark) begin
      beat.command   = CMD_NONE;
      beat.data_byte = 8'($urandom);
      if (sda_pick == SdaRand) beat.sda_level = 1'($urandom);
      else beat.sda_level = (sda_pick == SdaHigh);
      send_tick(beat);
    end
  endtask

  // bus idle, every result in, then the latency hold-off: safe for register writes
  task automatic settle_bus();
    run_to_idle(SdaRand);
    in_valid_i = 1'b0;
    while (pending_n != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // write all four timing registers, one per cycle
  task automatic program_timing(input logic [11:0] long_v, input logic [11:0] short_v,
                                input logic [11:0] sample_v, input logic [11:0] ack_v);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_LONG_PHASE;
    cfg_wdata_i = long_v;
    @(negedge clk_i);
    cfg_idx_i   = CFG_SHORT_PHASE;
    cfg_wdata_i = short_v;
    @(negedge clk_i);
    cfg_idx_i   = CFG_READ_SAMPLE;
    cfg_wdata_i = sample_v;
    @(negedge clk_i);
    cfg_idx_i   = CFG_ACK_WAIT;
    cfg_wdata_i = ack_v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // mostly complete command sequences, some cut short, some stray ticks;
  // halfway through the sender stops until every result is back
  task automatic random_traffic(input int budget);
    int       first;
    int       roll;
    bit       paused;
    in_item_t noise;
    first  = beats_in;
    paused = 1'b0;
    while (beats_in - first < budget) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        // any command code, often landing on a busy sequencer
        noise.command   = 3'($urandom);
        noise.data_byte = 8'($urandom);
        noise.sda_level = 1'($urandom);
        send_tick(noise);
      end else begin
        send_cmd(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom));
        if (roll < 85) run_to_idle(SdaRand);
        else repeat ($urandom_range(1, 6)) send_cmd(CMD_NONE, 8'($urandom));
      end
      if (!paused && beats_in - first >= budget / 2) begin
        in_valid_i = 1'b0;
        while (pending_n != 0) @(negedge clk_i);
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_LONG_PHASE;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset timing: one start, with a stop arriving mid-sequence (dropped)
    send_cmd(CMD_START, 8'($urandom));
    repeat (3) send_cmd(CMD_NONE, 8'($urandom));
    send_cmd(CMD_STOP, 8'($urandom));
    run_to_idle(SdaRand);
    settle_bus();

    // short phases: write and read, an all-ones data byte, unused codes
    program_timing(12'd2, 12'd1, 12'd1, 12'd3);
    send_cmd(CMD_WRITE, 8'hFF);
    run_to_idle(SdaRand);
    send_cmd(CMD_READ, 8'($urandom));
    run_to_idle(SdaRand);
    // codes above read act as plain ticks
    for (int code = CMD_READ + 1; code < 8; code++) send_cmd(3'(code), 8'($urandom));
    // back-to-back commands: the later ones hit a busy sequencer
    send_cmd(CMD_WRITE, 8'h3C);
    send_cmd(CMD_READ, 8'($urandom));
    send_cmd(CMD_STOP, 8'($urandom));
    run_to_idle(SdaLow);
    settle_bus();

    // all zero: lengths of zero count as one and the ack hold is skipped
    program_timing(12'd0, 12'd0, 12'd0, 12'd0);
    send_cmd(CMD_START, 8'($urandom));
    run_to_idle(SdaRand);
    send_cmd(CMD_WRITE, 8'h00);
    run_to_idle(SdaRand);
    send_cmd(CMD_STOP, 8'($urandom));
    run_to_idle(SdaRand);

    // random part: four idling modes, two timing settings each;
    // upper bits on the 8-bit registers are dropped by the block
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int pass = 0; pass < 2; pass++) begin
        settle_bus();
        program_timing(12'(($urandom_range(0, 15) << 8) | $urandom_range(0, 2)),
                       12'(($urandom_range(0, 15) << 8) | $urandom_range(0, 2)),
                       12'(($urandom_range(0, 15) << 8) | $urandom_range(0, 2)),
                       12'($urandom_range(0, 6)));
        // receiver holds off while the sender keeps offering ticks
        if (pass == 0 && (mode == 0 || mode == 2)) hold_asked++;
        random_traffic(8);
      end
    end

    settle_bus();
    if (fail_n == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
